>>> sv/fntl_pkg.sv
// fntl_pkg: shared types, codes and helpers for the file name table.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package fntl_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int NAME_BYTES_DEF    = 32;
    localparam int MAX_NAME_BYTES    = 32;
    localparam int MAX_NAME_BITS     = 8 * MAX_NAME_BYTES;

    typedef logic [63:0] t_word;

    // request word
    typedef struct packed {
        logic [1:0] kind;
        logic       mode;
        logic [7:0] handle;
        t_word      name_word0;
        t_word      name_word1;
        t_word      name_word2;
        t_word      name_word3;
        logic [7:0] name_len;
        logic       name_absent;
    } t_req;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NOT_FOUND    = 3'd1,
        ST_ALREADY_OPEN = 3'd2,
        ST_TABLE_FULL   = 3'd3,
        ST_NAME_NULL    = 3'd4,
        ST_TOO_LONG     = 3'd5,
        ST_BAD_HANDLE   = 3'd6
    } t_status;

    // response word
    typedef struct packed {
        t_status    status;
        logic [5:0] entry_index;
    } t_rsp;

    localparam logic [1:0] KIND_OPEN   = 2'd0;
    localparam logic [1:0] KIND_CLOSE  = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic MODE_WRITE = 1'b1;

    typedef logic [2:0] t_flags;
    localparam t_flags FLAG_NONE   = 3'b000;
    localparam t_flags FLAG_LOCKED = 3'b001;
    localparam t_flags FLAG_READ   = 3'b010;
    localparam t_flags FLAG_WRITE  = 3'b100;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_RESP
    } t_state;

    // bytes at or past the length read as zero
    function automatic logic [MAX_NAME_BITS-1:0] mask_name(input t_req r);
        logic [MAX_NAME_BITS-1:0] nm;
        nm = {r.name_word3, r.name_word2, r.name_word1, r.name_word0};
        for (int k = 0; k < MAX_NAME_BYTES; k++) begin
            if (8'(k) >= r.name_len) begin
                nm[8*k +: 8] = 8'h00;
            end
        end
        return nm;
    endfunction

endpackage

`default_nettype wire

>>> sv/fntl_if.sv
// Request and response channel interfaces (valid/ready plus payload word).
// Depends on fntl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface fntl_req_if;
    logic              valid;
    logic              ready;
    fntl_pkg::t_req    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fntl_rsp_if;
    logic              valid;
    logic              ready;
    fntl_pkg::t_rsp    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/fntl_name_store.sv
// Name store: one row per table entry, one write port, registered read,
// and the single name comparator used by the lookup scan. No package use.
`timescale 1ns / 1ps
`default_nettype none

module fntl_name_store #(
    parameter int ROWS     = 64,
    parameter int ROW_BITS = 256
) (
    input  wire                        i_clk,
    input  wire                        i_wr_en,
    input  wire  [$clog2(ROWS)-1:0]    i_wr_row,
    input  wire  [ROW_BITS-1:0]        i_wr_name,
    input  wire  [$clog2(ROWS)-1:0]    i_rd_row,
    input  wire  [ROW_BITS-1:0]        i_key,
    output logic                       o_eq
);

    logic [ROW_BITS-1:0] r_mem [ROWS];
    logic [ROW_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_name;
        end
        r_rd_data <= r_mem[i_rd_row];
    end

    // compare of the row read last cycle
    assign o_eq = (r_rd_data == i_key);

endmodule

`default_nettype wire

>>> sv/file_name_table_with_locks_top.sv
// File name table with lock flags and free list: top level.
// Depends on fntl_pkg, fntl_if (fntl_req_if, fntl_rsp_if) and fntl_name_store.
`timescale 1ns / 1ps
`default_nettype none

// A table of TABLE_ENTRIES named entries. Each request word is an open (read or
// write), a close or a remove; each gives exactly one response word with a
// status and, for a successful open, the entry handle. The block works on one
// request at a time and drops ready from acceptance until the response has
// been handed to the output register. Close and requests rejected on the name
// (absent, too long) or on the kind go straight to the response state. Open
// and remove walk the entries through the single name comparator, one entry
// per cycle, and stop at the first match; a write-open that misses then takes
// a new entry from the free list head if the list is not empty. The response
// register is separate from the sequencer, so a new request is taken while a
// response waits.
// No clearing pass is needed after reset: entry valid bits and link valid bits
// are flip-flops cleared by reset, and what the name and flag memories hold is
// used only for entries marked in use.

module file_name_table_with_locks_top #(
    parameter int TABLE_ENTRIES = fntl_pkg::TABLE_ENTRIES_DEF,
    parameter int NAME_BYTES    = fntl_pkg::NAME_BYTES_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    fntl_req_if.sink       i_req,
    fntl_rsp_if.source     o_rsp
);

    localparam int NAME_WORDS = (NAME_BYTES + 7) / 8;
    localparam int ROW_BITS   = NAME_WORDS * 64;
    localparam int IDX_W      = $clog2(TABLE_ENTRIES);
    localparam int LINK_W     = $clog2(TABLE_ENTRIES + 1);
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(TABLE_ENTRIES - 1);

    // sequencer
    fntl_pkg::t_state r_state, n_state;

    // latched request
    logic [1:0]          r_kind;
    logic                r_mode;
    logic [ROW_BITS-1:0] r_key;

    // scan address and read pipeline
    logic [IDX_W-1:0]    r_issue, n_issue;
    logic                r_issue_done, n_issue_done;
    logic                r_rd_vld;
    logic                r_rd_last;
    logic                r_rd_used;
    logic [IDX_W-1:0]    r_rd_idx;
    fntl_pkg::t_flags    r_flags_q;
    logic                name_eq;

    // entry state
    logic [TABLE_ENTRIES-1:0] r_used;
    fntl_pkg::t_flags         r_lock [TABLE_ENTRIES];
    logic [LINK_W-1:0]        r_link [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_link_vld;
    logic [LINK_W-1:0]        r_head, n_head;
    logic [LINK_W-1:0]        r_link_q;
    logic                     r_link_vld_q;
    logic [IDX_W-1:0]         head_idx;

    // pending result and output register
    fntl_pkg::t_status   r_res_status, n_res_status;
    logic [IDX_W-1:0]    r_res_idx, n_res_idx;
    logic                r_out_vld, n_out_vld;
    fntl_pkg::t_rsp      r_out;
    logic                out_load;

    // memory write controls
    logic                lk_we;
    logic [IDX_W-1:0]    lk_addr;
    fntl_pkg::t_flags    lk_data;
    logic                ln_we;
    logic [IDX_W-1:0]    ln_addr;
    logic                nm_we;
    logic                used_set, used_clr;
    logic [IDX_W-1:0]    used_addr;

    // input decode
    logic                in_acc;
    logic [31:0]         handle_ext;
    logic                handle_bad;
    logic                len_bad;
    logic                hit;
    logic [ROW_BITS-1:0] key_in;
    logic [fntl_pkg::MAX_NAME_BITS-1:0] key_full;

    assign in_acc      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == fntl_pkg::S_IDLE);
    assign handle_ext  = 32'(i_req.data.handle);
    assign handle_bad  = (handle_ext >= 32'(TABLE_ENTRIES));
    assign len_bad     = (i_req.data.name_len >= 8'(NAME_BYTES));
    assign key_full    = fntl_pkg::mask_name(i_req.data);
    assign key_in      = key_full[ROW_BITS-1:0];
    assign head_idx    = r_head[IDX_W-1:0];
    assign hit         = r_rd_vld && r_rd_used && name_eq;

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    fntl_name_store #(
        .ROWS     (TABLE_ENTRIES),
        .ROW_BITS (ROW_BITS)
    ) u_name_store (
        .i_clk     (i_clk),
        .i_wr_en   (nm_we),
        .i_wr_row  (head_idx),
        .i_wr_name (r_key),
        .i_rd_row  (r_issue),
        .i_key     (r_key),
        .o_eq      (name_eq)
    );

    // next state and memory controls
    always_comb begin
        n_state      = r_state;
        n_issue      = r_issue;
        n_issue_done = r_issue_done;
        n_head       = r_head;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_out_vld    = r_out_vld;
        out_load     = 1'b0;
        lk_we        = 1'b0;
        lk_addr      = r_rd_idx;
        lk_data      = fntl_pkg::FLAG_NONE;
        ln_we        = 1'b0;
        ln_addr      = r_rd_idx;
        nm_we        = 1'b0;
        used_set     = 1'b0;
        used_clr     = 1'b0;
        used_addr    = r_rd_idx;

        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            fntl_pkg::S_IDLE: begin
                n_issue      = '0;
                n_issue_done = 1'b0;
                n_res_idx    = '0;
                if (in_acc) begin
                    n_state = fntl_pkg::S_RESP;
                    case (i_req.data.kind)
                        fntl_pkg::KIND_CLOSE: begin
                            if (handle_bad) begin
                                n_res_status = fntl_pkg::ST_BAD_HANDLE;
                            end else begin
                                lk_we        = 1'b1;
                                lk_addr      = handle_ext[IDX_W-1:0];
                                n_res_status = fntl_pkg::ST_OK;
                            end
                        end
                        fntl_pkg::KIND_OPEN, fntl_pkg::KIND_REMOVE: begin
                            if (i_req.data.name_absent) begin
                                n_res_status = fntl_pkg::ST_NAME_NULL;
                            end else if (len_bad) begin
                                // no stored name can be that long
                                n_res_status = (i_req.data.kind == fntl_pkg::KIND_OPEN)
                                             ? fntl_pkg::ST_TOO_LONG
                                             : fntl_pkg::ST_NOT_FOUND;
                            end else begin
                                n_state = fntl_pkg::S_SCAN;
                            end
                        end
                        default: begin
                            n_res_status = fntl_pkg::ST_BAD_HANDLE;
                        end
                    endcase
                end
            end

            fntl_pkg::S_SCAN: begin
                if (!r_issue_done) begin
                    if (r_issue == IDX_LAST) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_issue = r_issue + 1'b1;
                    end
                end
                if (hit) begin
                    n_state = fntl_pkg::S_RESP;
                    if ((r_flags_q & fntl_pkg::FLAG_LOCKED) != fntl_pkg::FLAG_NONE) begin
                        n_res_status = fntl_pkg::ST_ALREADY_OPEN;
                    end else if (r_kind == fntl_pkg::KIND_OPEN) begin
                        lk_we        = 1'b1;
                        lk_data      = r_flags_q | fntl_pkg::FLAG_LOCKED
                                     | ((r_mode == fntl_pkg::MODE_WRITE)
                                        ? fntl_pkg::FLAG_WRITE : fntl_pkg::FLAG_READ);
                        n_res_status = fntl_pkg::ST_OK;
                        n_res_idx    = r_rd_idx;
                    end else begin
                        // remove: push onto the free list front
                        lk_we        = 1'b1;
                        used_clr     = 1'b1;
                        ln_we        = 1'b1;
                        n_head       = LINK_W'(r_rd_idx);
                        n_res_status = fntl_pkg::ST_OK;
                    end
                end else if (r_rd_vld && r_rd_last) begin
                    n_state = fntl_pkg::S_RESP;
                    if (r_kind == fntl_pkg::KIND_OPEN && r_mode == fntl_pkg::MODE_WRITE) begin
                        if (r_head == LINK_NONE) begin
                            n_res_status = fntl_pkg::ST_TABLE_FULL;
                        end else begin
                            n_state = fntl_pkg::S_FILL;
                        end
                    end else begin
                        n_res_status = fntl_pkg::ST_NOT_FOUND;
                    end
                end
            end

            fntl_pkg::S_FILL: begin
                // new entry at the free list head; link word read last cycle
                nm_we        = 1'b1;
                lk_we        = 1'b1;
                lk_addr      = head_idx;
                lk_data      = fntl_pkg::FLAG_LOCKED | fntl_pkg::FLAG_WRITE;
                used_set     = 1'b1;
                used_addr    = head_idx;
                n_head       = r_link_vld_q ? r_link_q : (r_head + 1'b1);
                n_res_status = fntl_pkg::ST_OK;
                n_res_idx    = head_idx;
                n_state      = fntl_pkg::S_RESP;
            end

            fntl_pkg::S_RESP: begin
                if (!r_out_vld || o_rsp.ready) begin
                    out_load  = 1'b1;
                    n_out_vld = 1'b1;
                    n_state   = fntl_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = fntl_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fntl_pkg::S_IDLE;
            r_out_vld    <= 1'b0;
            r_head       <= '0;
            r_used       <= '0;
            r_link_vld   <= '0;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_vld    <= n_out_vld;
            r_head       <= n_head;
            r_issue_done <= n_issue_done;
            r_rd_vld     <= (r_state == fntl_pkg::S_SCAN) && !r_issue_done;
            if (used_set) begin
                r_used[used_addr] <= 1'b1;
            end
            if (used_clr) begin
                r_used[used_addr] <= 1'b0;
            end
            if (ln_we) begin
                r_link_vld[ln_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_issue      <= n_issue;
        r_rd_idx     <= r_issue;
        r_rd_last    <= (r_issue == IDX_LAST);
        r_rd_used    <= r_used[r_issue];
        r_link_vld_q <= r_link_vld[head_idx];
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        if (in_acc) begin
            r_kind <= i_req.data.kind;
            r_mode <= i_req.data.mode;
            r_key  <= key_in;
        end
        if (out_load) begin
            r_out.status      <= r_res_status;
            r_out.entry_index <= 6'(32'(r_res_idx));
        end
    end

    // lock flag memory: read beside the name row during the scan
    always_ff @(posedge i_clk) begin
        if (lk_we) begin
            r_lock[lk_addr] <= lk_data;
        end
        r_flags_q <= r_lock[r_issue];
    end

    // free link memory; an unwritten entry links to the next index
    always_ff @(posedge i_clk) begin
        if (ln_we) begin
            r_link[ln_addr] <= r_head;
        end
        r_link_q <= r_link[head_idx];
    end

endmodule

`default_nettype wire

>>> sv/fntl_checker.sv
// Port-level checker for the file name table top, with its bind statement.
// Depends on fntl_pkg and file_name_table_with_locks_top.
`timescale 1ns / 1ps
`default_nettype none

module fntl_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_req_valid,
    input wire       i_req_ready,
    input wire       i_rsp_valid,
    input wire       i_rsp_ready,
    input wire [2:0] i_rsp_status,
    input wire [5:0] i_rsp_entry_index
);

    // held response word stays put until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_entry_index))
        else $error("response word changed while stalled");

    // one request at a time: busy right after accepting
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    // a failed request reports handle zero
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != fntl_pkg::ST_OK) |-> i_rsp_entry_index == 6'd0)
        else $error("nonzero handle on failed request");

    // no status code past bad handle
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_status <= fntl_pkg::ST_BAD_HANDLE)
        else $error("undefined status code");

endmodule

bind file_name_table_with_locks_top fntl_checker u_fntl_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.data.status),
    .i_rsp_entry_index (o_rsp.data.entry_index)
);

`default_nettype wire

>>> dv/fntl_table_check.sv
// fntl_table_check: watches the request and response channels of the file name
// table, predicts each response word and compares it. Depends on fntl_pkg, fntl_if.
`timescale 1ns / 1ps

module fntl_table_check #(
    parameter int TABLE_ENTRIES = 64,
    parameter int NAME_BYTES    = 32
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    fntl_req_if  i_req,
    fntl_rsp_if  i_rsp,
    output int   o_fault_count,
    output int   o_due_count
);

    import fntl_pkg::*;

    logic [MAX_NAME_BITS-1:0] held_name [TABLE_ENTRIES];
    t_flags                   lock_bits [TABLE_ENTRIES];
    bit                       in_use    [TABLE_ENTRIES];
    int                       free_next [TABLE_ENTRIES];
    int                       free_head;

    t_rsp due_responses [$];
    t_rsp want_rsp;
    t_rsp seen_rsp;

    // bytes at or past the length count as zero
    function automatic logic [MAX_NAME_BITS-1:0] trimmed_name(input t_req r);
        logic [MAX_NAME_BITS-1:0] nm;
        nm = {r.name_word3, r.name_word2, r.name_word1, r.name_word0};
        for (int k = 0; k < MAX_NAME_BYTES; k++) begin
            if (k >= int'(r.name_len)) begin
                nm[8*k +: 8] = 8'h00;
            end
        end
        return nm;
    endfunction

    function automatic int find_entry(input logic [MAX_NAME_BITS-1:0] nm);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (in_use[i] && held_name[i] == nm) begin
                return i;
            end
        end
        return TABLE_ENTRIES;
    endfunction

    // applies one request to the table copy, returns the response it gives
    function automatic t_rsp table_response(input t_req r);
        t_rsp                     res;
        logic [MAX_NAME_BITS-1:0] nm;
        int                       e;
        bit                       wr;
        res.status      = ST_OK;
        res.entry_index = '0;
        wr              = (r.mode == MODE_WRITE);
        nm              = trimmed_name(r);
        case (r.kind)
            KIND_OPEN: begin
                if (r.name_absent) begin
                    res.status = ST_NAME_NULL;
                end else if (int'(r.name_len) > NAME_BYTES - 1) begin
                    res.status = ST_TOO_LONG;
                end else begin
                    e = find_entry(nm);
                    if (e < TABLE_ENTRIES) begin
                        if ((lock_bits[e] & FLAG_LOCKED) != FLAG_NONE) begin
                            res.status = ST_ALREADY_OPEN;
                        end else begin
                            lock_bits[e] = lock_bits[e] | FLAG_LOCKED
                                         | (wr ? FLAG_WRITE : FLAG_READ);
                            res.entry_index = 6'(e);
                        end
                    end else if (!wr) begin
                        res.status = ST_NOT_FOUND;
                    end else if (free_head >= TABLE_ENTRIES) begin
                        res.status = ST_TABLE_FULL;
                    end else begin
                        e               = free_head;
                        held_name[e]    = nm;
                        lock_bits[e]    = FLAG_LOCKED | FLAG_WRITE;
                        in_use[e]       = 1'b1;
                        free_head       = free_next[e];
                        res.entry_index = 6'(e);
                    end
                end
            end
            KIND_CLOSE: begin
                if (int'(r.handle) >= TABLE_ENTRIES) begin
                    res.status = ST_BAD_HANDLE;
                end else begin
                    lock_bits[r.handle] = FLAG_NONE;
                end
            end
            KIND_REMOVE: begin
                if (r.name_absent) begin
                    res.status = ST_NAME_NULL;
                end else if (int'(r.name_len) > NAME_BYTES - 1) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    e = find_entry(nm);
                    if (e >= TABLE_ENTRIES) begin
                        res.status = ST_NOT_FOUND;
                    end else if ((lock_bits[e] & FLAG_LOCKED) != FLAG_NONE) begin
                        res.status = ST_ALREADY_OPEN;
                    end else begin
                        held_name[e] = '0;
                        lock_bits[e] = FLAG_NONE;
                        in_use[e]    = 1'b0;
                        free_next[e] = free_head;
                        free_head    = e;
                    end
                end
            end
            default: begin
                res.status = ST_BAD_HANDLE;
            end
        endcase
        return res;
    endfunction

    task automatic log_fault(input string msg);
        if (o_fault_count < 10) begin
            $display("%0t ns: %s", $time, msg);
        end
        o_fault_count++;
    endtask

    // response side first, so a word accepted on the same edge queues behind
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                held_name[i] = '0;
                lock_bits[i] = FLAG_NONE;
                in_use[i]    = 1'b0;
                free_next[i] = i + 1;
            end
            free_head = 0;
            due_responses.delete();
            o_fault_count = 0;
            o_due_count   = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                seen_rsp = i_rsp.data;
                if (due_responses.size() == 0) begin
                    log_fault($sformatf("unexpected response word: status %0d index %0d",
                                        seen_rsp.status, seen_rsp.entry_index));
                end else begin
                    want_rsp = due_responses.pop_front();
                    if (seen_rsp.status !== want_rsp.status) begin
                        log_fault($sformatf("status: expected %0d, got %0d",
                                            want_rsp.status, seen_rsp.status));
                    end
                    if (seen_rsp.entry_index !== want_rsp.entry_index) begin
                        log_fault($sformatf("entry_index: expected %0d, got %0d",
                                            want_rsp.entry_index, seen_rsp.entry_index));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                due_responses.push_back(table_response(i_req.data));
            end
            o_due_count = due_responses.size();
        end
    end

endmodule

>>> dv/file_name_table_with_locks_top_test.sv
// Testbench top for the file name table: drives request words, paces the
// response side, gives the verdict. Depends on fntl_pkg, fntl_if, fntl_table_check.
`timescale 1ns / 1ps

module file_name_table_with_locks_top_test;

    import fntl_pkg::*;

    localparam int ENTRIES      = 64;
    localparam int NBYTES       = 32;
    localparam int POOL         = 96;    // more names than entries, so the table fills
    localparam int RANDOM_WORDS = 950;
    localparam int END_WAIT     = 80;
    localparam int CYCLE_LIMIT  = 1_000_000;

    // the request kind the block does not define
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic       MODE_READ  = 1'b0;

    logic clk;
    logic rst_n;

    fntl_req_if req_ch ();
    fntl_rsp_if rsp_ch ();

    int fault_count;
    int due_count;
    int cycle_count = 0;
    int stall_left  = 0;
    bit calm        = 1'b0;   // no idling on either side while set
    bit fill_bias   = 1'b1;   // favor write-opens (fill) or close/remove (drain)

    // name pool: stimulus picks names from here so that they repeat
    logic [MAX_NAME_BITS-1:0] pool_name [POOL];
    logic [7:0]               pool_len  [POOL];

    file_name_table_with_locks_top #(
        .TABLE_ENTRIES (ENTRIES),
        .NAME_BYTES    (NBYTES)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    fntl_table_check #(
        .TABLE_ENTRIES (ENTRIES),
        .NAME_BYTES    (NBYTES)
    ) u_table_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_fault_count (fault_count),
        .o_due_count   (due_count)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop in case the block hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pause_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [MAX_NAME_BITS-1:0] wide_random();
        logic [MAX_NAME_BITS-1:0] v;
        for (int i = 0; i < MAX_NAME_BITS / 32; i++) begin
            v[32*i +: 32] = $urandom;
        end
        return v;
    endfunction

    // Request word carrying pool name p. Bytes past the length are either zero
    // or junk; the block has to ignore them either way. Handle gets random
    // filler so its bits move even when the kind does not use it.
    function automatic t_req name_req(input logic [1:0] kind, input logic mode,
                                      input int p);
        t_req                     r;
        logic [MAX_NAME_BITS-1:0] keep;
        logic [MAX_NAME_BITS-1:0] bits;
        keep = '0;
        for (int k = 0; k < MAX_NAME_BYTES; k++) begin
            if (k < int'(pool_len[p])) keep[8*k +: 8] = 8'hFF;
        end
        bits = pool_name[p] & keep;
        if ($urandom_range(0, 1) == 1) begin
            bits = bits | (wide_random() & ~keep);
        end
        r.kind        = kind;
        r.mode        = mode;
        r.handle      = 8'($urandom_range(0, 255));
        r.name_word0  = bits[63:0];
        r.name_word1  = bits[127:64];
        r.name_word2  = bits[191:128];
        r.name_word3  = bits[255:192];
        r.name_len    = pool_len[p];
        r.name_absent = 1'b0;
        return r;
    endfunction

    function automatic t_req close_req(input int h);
        t_req r;
        r        = name_req(KIND_CLOSE, 1'($urandom_range(0, 1)),
                            $urandom_range(0, POOL - 1));
        r.handle = 8'(h);
        return r;
    endfunction

    // Malformed or rejected words: absent name, over-long name, the undefined
    // kind, out-of-range close handle.
    function automatic t_req noise_req();
        t_req                     r;
        logic [MAX_NAME_BITS-1:0] bits;
        r = name_req(($urandom_range(0, 1) == 1) ? KIND_OPEN : KIND_REMOVE,
                     1'($urandom_range(0, 1)), $urandom_range(0, POOL - 1));
        case ($urandom_range(0, 3))
            0: begin
                r.name_absent = 1'b1;
                r.name_len    = 8'($urandom_range(0, 255));
            end
            1: begin
                bits          = wide_random();
                r.name_word0  = bits[63:0];
                r.name_word1  = bits[127:64];
                r.name_word2  = bits[191:128];
                r.name_word3  = bits[255:192];
                r.name_len    = ($urandom_range(0, 3) == 0)
                              ? 8'd255 : 8'($urandom_range(NBYTES, 255));
            end
            2: begin
                r.kind = KIND_SPARE;
            end
            default: begin
                r = close_req($urandom_range(ENTRIES, 255));
            end
        endcase
        return r;
    endfunction

    // Random traffic, weighted toward filling or toward draining the table.
    function automatic t_req random_req();
        int roll;
        int p;
        int cut_wr;
        int cut_rd;
        int cut_cl;
        roll   = $urandom_range(0, 99);
        p      = $urandom_range(0, POOL - 1);
        cut_wr = fill_bias ? 45 : 15;
        cut_rd = cut_wr + 15;
        cut_cl = fill_bias ? 80 : 60;
        if (roll < cut_wr) return name_req(KIND_OPEN, MODE_WRITE, p);
        if (roll < cut_rd) return name_req(KIND_OPEN, MODE_READ, p);
        if (roll < cut_cl) return close_req($urandom_range(0, ENTRIES - 1));
        if (roll < 92)     return name_req(KIND_REMOVE, 1'($urandom_range(0, 1)), p);
        return noise_req();
    endfunction

    // Entered and left at a falling edge. valid is dropped only for a gap, so
    // back-to-back words keep it high across the boundary.
    task automatic send_req(input t_req r);
        int gap;
        gap = calm ? 0 : pause_len();
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.data  = r;
        req_ch.valid = 1'b1;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Hold the sender until every outstanding response word has come back.
    task automatic wait_drained();
        req_ch.valid = 1'b0;
        do @(negedge clk); while (due_count != 0);
    endtask

    // The first four names are fixed for the directed part: the empty name, a
    // name of the longest legal length, and two names with a zero byte inside
    // the length where one is a prefix of the other. Every eighth random name
    // extends the one before it by a byte, so near-duplicates must not match.
    task automatic build_pool();
        int len;
        pool_name[0] = '0;
        pool_len[0]  = 8'd0;
        pool_name[1] = '0;
        for (int k = 0; k < NBYTES - 1; k++) begin
            pool_name[1][8*k +: 8] = 8'($urandom_range(1, 255));
        end
        pool_len[1]  = 8'(NBYTES - 1);
        pool_name[2] = {232'd0, 8'h62, 8'h00, 8'h61};
        pool_len[2]  = 8'd3;
        pool_name[3] = {240'd0, 8'h00, 8'h61};
        pool_len[3]  = 8'd2;
        for (int p = 4; p < POOL; p++) begin
            if (p % 8 == 0 && pool_len[p - 1] < NBYTES - 1) begin
                len          = int'(pool_len[p - 1]);
                pool_name[p] = pool_name[p - 1];
                pool_name[p][8*len +: 8] = 8'($urandom_range(0, 255));
                pool_len[p]  = 8'(len + 1);
            end else begin
                len          = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NBYTES - 1)
                                                           : $urandom_range(1, 10);
                pool_name[p] = '0;
                for (int k = 0; k < len; k++) begin
                    pool_name[p][8*k +: 8] = ($urandom_range(0, 7) == 0)
                                           ? 8'h00 : 8'($urandom_range(1, 255));
                end
                pool_len[p]  = 8'(len);
            end
        end
    endtask

    // Directed walk through every status but table_full, and the odd corners.
    task automatic run_directed();
        t_req r;
        send_req(name_req(KIND_OPEN, MODE_READ, 1));         // unknown name: not_found
        r = name_req(KIND_OPEN, MODE_WRITE, 1);
        r.name_absent = 1'b1;
        send_req(r);                                         // name_null
        r = name_req(KIND_OPEN, MODE_WRITE, 1);
        r.name_len = 8'(NBYTES);
        send_req(r);                                         // one byte over: too_long
        r.name_len = 8'd255;
        send_req(r);                                         // saturated length
        send_req(name_req(KIND_OPEN, MODE_WRITE, 0));        // empty name takes entry 0
        send_req(name_req(KIND_OPEN, MODE_WRITE, 1));        // longest name, entry 1
        send_req(name_req(KIND_OPEN, MODE_WRITE, 1));        // locked: already_open
        send_req(name_req(KIND_OPEN, MODE_READ, 1));         // locked in read mode too
        send_req(name_req(KIND_REMOVE, MODE_READ, 1));       // remove while locked
        send_req(close_req(1));
        send_req(close_req(ENTRIES));                        // just past the table
        send_req(close_req(255));
        send_req(close_req(ENTRIES - 1));                    // entry never used: still ok
        send_req(name_req(KIND_OPEN, MODE_READ, 1));         // read-open of existing name
        send_req(close_req(1));
        send_req(name_req(KIND_REMOVE, MODE_WRITE, 1));      // frees entry 1 to list front
        send_req(name_req(KIND_REMOVE, MODE_WRITE, 1));      // gone: not_found
        r = name_req(KIND_REMOVE, MODE_READ, 2);
        r.name_absent = 1'b1;
        send_req(r);                                         // remove, no name
        r = name_req(KIND_REMOVE, MODE_READ, 2);
        r.name_len = 8'd40;
        send_req(r);                                         // remove, over-long name
        r = name_req(KIND_SPARE, MODE_WRITE, 2);
        send_req(r);                                         // undefined kind
        send_req(name_req(KIND_OPEN, MODE_WRITE, 2));        // reuses entry 1
        send_req(name_req(KIND_OPEN, MODE_WRITE, 3));        // prefix, zero byte inside
        send_req(name_req(KIND_OPEN, MODE_WRITE, 2));        // already_open
    endtask

    // Response side: random stalls unless in a calm stretch.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = pause_len();
            end
            rsp_ch.ready = (stall_left == 0);
        end
    end

    // Request side and verdict.
    initial begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        build_pool();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        wait_drained();

        // Segments of 120 words alternate fill and drain, so the table runs
        // into table_full and back; some segments run with no idling at all.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 120 == 0) begin
                fill_bias = ((n / 120) % 2 == 0);
                calm      = ($urandom_range(0, 3) == 0);
            end
            if (n % 300 == 150) begin
                wait_drained();
            end
            send_req(random_req());
        end

        wait_drained();
        repeat (END_WAIT) @(negedge clk);
        if (fault_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
